/* hdl/nscm_pkg.sv */
// ---------------------------------------------------------------------------
// nscm_pkg : shared types and helpers for the scale-or-center pixel mapper
// Field widths, register indexes, reset values, and one restoring
// divider step used by the pipelined quotient chain.
// ---------------------------------------------------------------------------
package nscm_pkg;

   // field widths
   localparam int unsigned SIDE_W    = 12;
   localparam int unsigned IDX_W     = 24;
   localparam int unsigned CSR_IDX_W = 2;

   // one past the largest legal side length, register writes saturate below it
   localparam int unsigned MAX_SIDE  = 4096;
   localparam logic [SIDE_W+1:0] SIDE_LIMIT = (SIDE_W+2)'(MAX_SIDE - 1);

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH     = 2'd0,
      CSR_SRC_HEIGHT    = 2'd1,
      CSR_SCREEN_WIDTH  = 2'd2,
      CSR_SCREEN_HEIGHT = 2'd3
   } csr_index_type;

   // register reset values
   localparam logic [SIDE_W-1:0] RST_SRC_WIDTH     = 12'd1;
   localparam logic [SIDE_W-1:0] RST_SRC_HEIGHT    = 12'd1;
   localparam logic [SIDE_W-1:0] RST_SCREEN_WIDTH  = 12'd1024;
   localparam logic [SIDE_W-1:0] RST_SCREEN_HEIGHT = 12'd600;

   // one axis of the divider: partial remainder, dividend bits still to
   // shift in, quotient bits so far
   typedef struct packed {
      logic [SIDE_W-1:0] rem;
      logic [SIDE_W-1:0] num;
      logic [SIDE_W-1:0] quot;
   } div_type;

   // after the multiply stage
   typedef struct packed {
      logic [IDX_W-1:0]  scr_prod;
      logic [SIDE_W-1:0] x;
      logic [SIDE_W-1:0] dx;
      logic [SIDE_W-1:0] dy;
      logic              bg;
      logic              scaled;
   } mul_item_type;

   // carried through the divider chain
   typedef struct packed {
      logic [IDX_W-1:0]  scr_idx;
      logic [SIDE_W-1:0] dx;
      logic [SIDE_W-1:0] dy;
      logic              bg;
      logic              scaled;
   } div_item_type;

   // after the source row multiply
   typedef struct packed {
      logic [IDX_W-1:0]  scr_idx;
      logic [IDX_W-1:0]  row_prod;
      logic [SIDE_W-1:0] col;
      logic              bg;
      logic              scaled;
   } row_item_type;

   // clamp a written side length
   function automatic logic [SIDE_W-1:0] sat_side(logic [SIDE_W-1:0] v);
      logic [SIDE_W+1:0] wide;
      wide = {2'b00, v};
      if (wide > SIDE_LIMIT) begin
         return SIDE_LIMIT[SIDE_W-1:0];
      end
      return v;
   endfunction

   // one restoring division step, one quotient bit
   function automatic div_type div_step(div_type cur, logic [SIDE_W-1:0] dvsr);
      logic [SIDE_W:0] trial;
      logic [SIDE_W:0] diff;
      logic            ge;
      div_type         nxt;
      trial    = {cur.rem, cur.num[SIDE_W-1]};
      diff     = trial - {1'b0, dvsr};
      ge       = (trial >= {1'b0, dvsr});
      nxt.rem  = ge ? diff[SIDE_W-1:0] : trial[SIDE_W-1:0];
      nxt.num  = {cur.num[SIDE_W-2:0], 1'b0};
      nxt.quot = {cur.quot[SIDE_W-2:0], ge};
      return nxt;
   endfunction

endpackage

/* hdl/nearest_scale_or_center_mapper.sv */
// ---------------------------------------------------------------------------
// nearest_scale_or_center_mapper : screen pixel to source pixel mapper
// Scales the source by nearest neighbor when it exceeds the screen in
// either side, else centers it and flags uncovered pixels as background.
// ---------------------------------------------------------------------------
//
//  channel  | ports                               | direction
//  ---------+-------------------------------------+-----------
//  req      | req_valid req_stall req_pix_x/y     | in
//  rsp      | rsp_valid rsp_stall rsp_screen_index| out
//           | rsp_source_index rsp_background     |
//           | rsp_scaled                          |
//  csr      | csr_valid csr_ready csr_index       | in
//           | csr_wdata                           |
//
//  One beat per cycle while rsp_stall is low; req reaches rsp through the
//  input and multiply stages, the 12-step restoring divider chain (one
//  quotient bit per stage), and the row multiply and output stages.
//  Synchronous active-high reset clears valid bits and presets the csr registers.
//  A stall on rsp only holds stages that are full; bubbles still close up,
//  and req_stall rises only when the first stage cannot move.
//  csr_ready is always high; writes take effect on the next cycle.
//
module nearest_scale_or_center_mapper (
   input  logic                          clock,
   input  logic                          reset,
   // input beats
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [nscm_pkg::SIDE_W-1:0]   req_pix_x,
   input  logic [nscm_pkg::SIDE_W-1:0]   req_pix_y,
   // result beats
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [nscm_pkg::IDX_W-1:0]    rsp_screen_index,
   output logic [nscm_pkg::IDX_W-1:0]    rsp_source_index,
   output logic                          rsp_background,
   output logic                          rsp_scaled,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [nscm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nscm_pkg::SIDE_W-1:0]   csr_wdata
);

   localparam int unsigned SW       = nscm_pkg::SIDE_W;
   localparam int unsigned IW       = nscm_pkg::IDX_W;
   localparam int unsigned DIV_N    = SW;
   localparam int unsigned ST_IN    = 0;
   localparam int unsigned ST_MUL   = 1;
   localparam int unsigned DIV_BASE = 2;
   localparam int unsigned ST_ROW   = DIV_BASE + DIV_N;
   localparam int unsigned ST_OUT   = ST_ROW + 1;
   localparam int unsigned NSTG     = ST_OUT + 1;

   // configuration registers
   logic [SW-1:0] src_w_ff, src_h_ff, scr_w_ff, scr_h_ff;
   logic [SW-1:0] wdata_sat;

   // pipeline valid bits and advance enables
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] adv;

   // stage registers
   logic [SW-1:0]                pix_x_ff, pix_y_ff;
   nscm_pkg::mul_item_type       mul_ff, mul_in;
   logic [IW-1:0]                nx_ff, ny_ff, nx_in, ny_in;
   nscm_pkg::div_type            divx_ff [DIV_N];
   nscm_pkg::div_type            divy_ff [DIV_N];
   nscm_pkg::div_item_type       ditem_ff [DIV_N];
   nscm_pkg::row_item_type       row_ff, row_in;
   logic [IW-1:0]                scr_out_ff, src_out_ff;
   logic                         bg_out_ff, scaled_out_ff;

   // ------------------------------------------------------------------
   // register port
   assign csr_ready = 1'b1;
   assign wdata_sat = nscm_pkg::sat_side(csr_wdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= nscm_pkg::RST_SRC_WIDTH;
         src_h_ff <= nscm_pkg::RST_SRC_HEIGHT;
         scr_w_ff <= nscm_pkg::RST_SCREEN_WIDTH;
         scr_h_ff <= nscm_pkg::RST_SCREEN_HEIGHT;
      end else if (csr_valid && csr_ready) begin
         case (nscm_pkg::csr_index_type'(csr_index))
            nscm_pkg::CSR_SRC_WIDTH:     src_w_ff <= wdata_sat;
            nscm_pkg::CSR_SRC_HEIGHT:    src_h_ff <= wdata_sat;
            nscm_pkg::CSR_SCREEN_WIDTH:  scr_w_ff <= wdata_sat;
            nscm_pkg::CSR_SCREEN_HEIGHT: scr_h_ff <= wdata_sat;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // advance enables: a stage moves when empty or when the next one moves
   assign adv[NSTG-1] = !vld_ff[NSTG-1] || !rsp_stall;
   for (genvar k = 0; k < NSTG - 1; k++) begin : g_adv
      assign adv[k] = !vld_ff[k] || adv[k+1];
   end

   assign req_stall = !adv[ST_IN];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[ST_IN]) begin
            vld_ff[ST_IN] <= req_valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // input stage
   always_ff @(posedge clock) begin
      if (adv[ST_IN]) begin
         pix_x_ff <= req_pix_x;
         pix_y_ff <= req_pix_y;
      end
   end

   // ------------------------------------------------------------------
   // multiply stage: scale numerators, screen row product, centering window
   logic          scaled_w, on_scr_w, in_win_w;
   logic [SW-1:0] x0_w, y0_w;
   logic [SW:0]   x_end_w, y_end_w;

   always_comb begin
      scaled_w = (src_w_ff > scr_w_ff) || (src_h_ff > scr_h_ff);
      on_scr_w = (pix_x_ff < scr_w_ff) && (pix_y_ff < scr_h_ff);
      x0_w     = SW'((scr_w_ff - src_w_ff) >> 1);
      y0_w     = SW'((scr_h_ff - src_h_ff) >> 1);
      x_end_w  = {1'b0, x0_w} + {1'b0, src_w_ff};
      y_end_w  = {1'b0, y0_w} + {1'b0, src_h_ff};
      in_win_w = (pix_x_ff >= x0_w) && ({1'b0, pix_x_ff} < x_end_w) &&
                 (pix_y_ff >= y0_w) && ({1'b0, pix_y_ff} < y_end_w);

      nx_in = {{(IW-SW){1'b0}}, pix_x_ff} * {{(IW-SW){1'b0}}, src_w_ff};
      ny_in = {{(IW-SW){1'b0}}, pix_y_ff} * {{(IW-SW){1'b0}}, src_h_ff};

      mul_in.scr_prod = {{(IW-SW){1'b0}}, pix_y_ff} * {{(IW-SW){1'b0}}, scr_w_ff};
      mul_in.x        = pix_x_ff;
      mul_in.dx       = pix_x_ff - x0_w;
      mul_in.dy       = pix_y_ff - y0_w;
      mul_in.bg       = !on_scr_w || (!scaled_w && !in_win_w);
      mul_in.scaled   = scaled_w;
   end

   always_ff @(posedge clock) begin
      if (adv[ST_MUL]) begin
         mul_ff <= mul_in;
         nx_ff  <= nx_in;
         ny_ff  <= ny_in;
      end
   end

   // ------------------------------------------------------------------
   // divider chain: one quotient bit per stage on each axis
   // numerator < divisor * 2^SW when on screen, so the top half starts
   // below the divisor and the quotient fits SW bits
   for (genvar k = 0; k < DIV_N; k++) begin : g_div
      nscm_pkg::div_type      srcx, srcy;
      nscm_pkg::div_item_type item_in;

      if (k == 0) begin : g_first
         assign srcx.rem  = nx_ff[IW-1:SW];
         assign srcx.num  = nx_ff[SW-1:0];
         assign srcx.quot = '0;
         assign srcy.rem  = ny_ff[IW-1:SW];
         assign srcy.num  = ny_ff[SW-1:0];
         assign srcy.quot = '0;
         // screen index add rides along in the first divider stage
         assign item_in.scr_idx = mul_ff.scr_prod + {{(IW-SW){1'b0}}, mul_ff.x};
         assign item_in.dx      = mul_ff.dx;
         assign item_in.dy      = mul_ff.dy;
         assign item_in.bg      = mul_ff.bg;
         assign item_in.scaled  = mul_ff.scaled;
      end else begin : g_next
         assign srcx    = divx_ff[k-1];
         assign srcy    = divy_ff[k-1];
         assign item_in = ditem_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (adv[DIV_BASE+k]) begin
            divx_ff[k]  <= nscm_pkg::div_step(srcx, scr_w_ff);
            divy_ff[k]  <= nscm_pkg::div_step(srcy, scr_h_ff);
            ditem_ff[k] <= item_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // source row multiply, shared by both modes
   logic [SW-1:0] row_sel, col_sel;

   always_comb begin
      row_sel = ditem_ff[DIV_N-1].scaled ? divy_ff[DIV_N-1].quot : ditem_ff[DIV_N-1].dy;
      col_sel = ditem_ff[DIV_N-1].scaled ? divx_ff[DIV_N-1].quot : ditem_ff[DIV_N-1].dx;
      row_in.scr_idx  = ditem_ff[DIV_N-1].scr_idx;
      row_in.row_prod = {{(IW-SW){1'b0}}, row_sel} * {{(IW-SW){1'b0}}, src_w_ff};
      row_in.col      = col_sel;
      row_in.bg       = ditem_ff[DIV_N-1].bg;
      row_in.scaled   = ditem_ff[DIV_N-1].scaled;
   end

   always_ff @(posedge clock) begin
      if (adv[ST_ROW]) begin
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------
   // output register
   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         scr_out_ff    <= row_ff.scr_idx;
         src_out_ff    <= row_ff.bg ? '0 :
                          row_ff.row_prod + {{(IW-SW){1'b0}}, row_ff.col};
         bg_out_ff     <= row_ff.bg;
         scaled_out_ff <= row_ff.scaled;
      end
   end

   assign rsp_valid        = vld_ff[ST_OUT];
   assign rsp_screen_index = scr_out_ff;
   assign rsp_source_index = src_out_ff;
   assign rsp_background   = bg_out_ff;
   assign rsp_scaled       = scaled_out_ff;

   // ------------------------------------------------------------------
   // checks

   // background beats never carry a source index
   a_bg_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_background |-> rsp_source_index == '0)
      else $error("background beat with nonzero source index");

   // scaled column quotient stays inside the source width
   a_quot_x : assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_ROW-1] && ditem_ff[DIV_N-1].scaled && !ditem_ff[DIV_N-1].bg
      |-> divx_ff[DIV_N-1].quot < src_w_ff)
      else $error("column quotient out of source range");

   // scaled row quotient stays inside the source height
   a_quot_y : assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_ROW-1] && ditem_ff[DIV_N-1].scaled && !ditem_ff[DIV_N-1].bg
      |-> divy_ff[DIV_N-1].quot < src_h_ff)
      else $error("row quotient out of source range");

   // no back pressure on the input without back pressure on the output
   a_no_false_stall : assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output is free");

endmodule
